// ===== design/pfx_pkg.sv =====
// Shared constants, types and helper functions for the pixel format to XRGB core.
// Depends on nothing; the core references it by scoped names.
package pfx_pkg;

   // Q8 color conversion coefficients (1.13983, 0.39465, 0.58060, 2.03211 times 256).
   localparam int AccWidth = 19;
   localparam logic signed [AccWidth-1:0] COEF_RV = 19'sd292;
   localparam logic signed [AccWidth-1:0] COEF_GU = 19'sd101;
   localparam logic signed [AccWidth-1:0] COEF_GV = 19'sd149;
   localparam logic signed [AccWidth-1:0] COEF_BU = 19'sd520;

   localparam logic [7:0] ALPHA_OPAQUE = 8'hFF;

   // Register byte addresses, as word indexes.
   localparam logic REG_CONVERSION_MODE = 1'b0;

   typedef enum logic {
      MODE_YUY2  = 1'b0,
      MODE_RGB24 = 1'b1
   } mode_type;

   typedef logic signed [AccWidth-1:0] acc_type;

   // Floor divide by 256 (arithmetic shift) and clamp to 0..255.
   function automatic logic [7:0] clamp_q8(input acc_type acc);
      logic signed [AccWidth-9:0] q;
      q = acc[AccWidth-1:8];
      if (q[AccWidth-9]) begin
         clamp_q8 = 8'd0;
      end else if (q[AccWidth-10:8] != '0) begin
         clamp_q8 = 8'd255;
      end else begin
         clamp_q8 = q[7:0];
      end
   endfunction

   // Byte minus 128 as a sign-extended accumulator value.
   function automatic acc_type center_chroma(input logic [7:0] c);
      logic signed [8:0] s;
      s = {~c[7], ~c[7], c[6:0]};
      center_chroma = {{(AccWidth-9){s[8]}}, s};
   endfunction

endpackage

// ===== design/pixel_format_to_xrgb_core.sv =====
// Pixel format to XRGB core: YUY2 macropixel or RGB24 pixel in, 32-bit XRGB pixels out.
// Depends on pfx_pkg for coefficients, types and the clamp helper.
//
// An input transfer goes through the issue, multiply, sum and clamp stages before its
// first pixel is on rsp. Throughput, set by the issue stage: one pixel per cycle while
// rsp_ready does not stall; a full YUY2 macropixel gives two pixels, a tail or RGB24 one.
// Reset is synchronous and active high; it empties every stage and sets YUY2 mode.
module pixel_format_to_xrgb_core (
   input  logic        clock,
   input  logic        reset,
   // Input channel.
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_byte_a,
   input  logic [7:0]  req_byte_b,
   input  logic [7:0]  req_byte_c,
   input  logic [7:0]  req_byte_d,
   input  logic        req_one_pixel_only,
   // Result channel.
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [7:0]  rsp_red,
   output logic [7:0]  rsp_green,
   output logic [7:0]  rsp_blue,
   output logic [7:0]  rsp_alpha,
   output logic        rsp_last,
   // Configuration port.
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [2:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);

   // ------------------------------------------------------------------
   // Configuration register. Writes complete on the access cycle; the
   // low address bits are the byte offset and are not decoded.
   // ------------------------------------------------------------------
   pfx_pkg::mode_type mode_ff, mode_in;
   logic              csr_write;

   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite && pready;

   always_comb begin
      mode_in = mode_ff;
      if (csr_write && (paddr[2] == pfx_pkg::REG_CONVERSION_MODE)) begin
         mode_in = pfx_pkg::mode_type'(pwdata[0]);
      end
   end

   always_comb begin
      prdata = '0;
      if (paddr[2] == pfx_pkg::REG_CONVERSION_MODE) begin
         prdata = {31'd0, mode_ff};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= pfx_pkg::MODE_YUY2;
      end else begin
         mode_ff <= mode_in;
      end
   end

   // ------------------------------------------------------------------
   // Stage advance terms. A stage may take new data when it is empty or
   // when its content moves on in the same cycle.
   // ------------------------------------------------------------------
   logic s1_v_ff, s1_v_in;
   logic s2_v_ff, s2_v_in;
   logic s3_v_ff, s3_v_in;
   logic s1_adv, s2_adv, s3_adv;

   assign s3_adv = !s3_v_ff || rsp_ready;
   assign s2_adv = !s2_v_ff || s3_adv;
   assign s1_adv = !s1_v_ff || s2_adv;

   // ------------------------------------------------------------------
   // Stage 0: issue. Holds one input item and hands it to the pipeline
   // as one pixel per cycle while stage 1 can advance. A full YUY2
   // macropixel issues Y0 and then Y1; the item is done once its last
   // pixel is issued, and a new transfer may land in that same cycle.
   // ------------------------------------------------------------------
   logic              s0_v_ff, s0_v_in;
   logic              s0_phase_ff, s0_phase_in;
   pfx_pkg::mode_type s0_mode_ff, s0_mode_in;
   logic              s0_tail_ff, s0_tail_in;
   logic [7:0]        s0_a_ff, s0_a_in;
   logic [7:0]        s0_b_ff, s0_b_in;
   logic [7:0]        s0_c_ff, s0_c_in;
   logic [7:0]        s0_d_ff, s0_d_in;
   logic              issue, done, accept;

   assign done      = (s0_mode_ff == pfx_pkg::MODE_RGB24) || s0_tail_ff || s0_phase_ff;
   assign issue     = s0_v_ff && s1_adv;
   assign req_ready = !s0_v_ff || (s1_adv && done);
   assign accept    = req_valid && req_ready;

   always_comb begin
      s0_v_in     = s0_v_ff;
      s0_phase_in = s0_phase_ff;
      s0_mode_in  = s0_mode_ff;
      s0_tail_in  = s0_tail_ff;
      s0_a_in     = s0_a_ff;
      s0_b_in     = s0_b_ff;
      s0_c_in     = s0_c_ff;
      s0_d_in     = s0_d_ff;
      if (accept) begin
         s0_v_in     = 1'b1;
         s0_phase_in = 1'b0;
         s0_mode_in  = mode_ff;
         s0_tail_in  = req_one_pixel_only;
         s0_a_in     = req_byte_a;
         s0_b_in     = req_byte_b;
         s0_c_in     = req_byte_c;
         s0_d_in     = req_byte_d;
      end else if (issue) begin
         if (done) begin
            s0_v_in     = 1'b0;
            s0_phase_in = 1'b0;
         end else begin
            s0_phase_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s0_v_ff     <= 1'b0;
         s0_phase_ff <= 1'b0;
      end else begin
         s0_v_ff     <= s0_v_in;
         s0_phase_ff <= s0_phase_in;
      end
      s0_mode_ff <= s0_mode_in;
      s0_tail_ff <= s0_tail_in;
      s0_a_ff    <= s0_a_in;
      s0_b_ff    <= s0_b_in;
      s0_c_ff    <= s0_c_in;
      s0_d_ff    <= s0_d_in;
   end

   // ------------------------------------------------------------------
   // Stage 1: products. Each channel gets a base of its byte times 256
   // plus chroma products. In RGB24 mode the bases are the color
   // bytes times 256 and the products are zero, so the later stages
   // pass the bytes through unchanged.
   // ------------------------------------------------------------------
   logic [15:0]       s1_base_r_ff, s1_base_r_in;
   logic [15:0]       s1_base_g_ff, s1_base_g_in;
   logic [15:0]       s1_base_b_ff, s1_base_b_in;
   pfx_pkg::acc_type  s1_rv_ff, s1_rv_in;
   pfx_pkg::acc_type  s1_gu_ff, s1_gu_in;
   pfx_pkg::acc_type  s1_gv_ff, s1_gv_in;
   pfx_pkg::acc_type  s1_bu_ff, s1_bu_in;
   logic              s1_last_ff, s1_last_in;
   pfx_pkg::acc_type  u_c, v_c;
   logic [7:0]        luma;

   assign u_c  = pfx_pkg::center_chroma(s0_b_ff);
   assign v_c  = pfx_pkg::center_chroma(s0_d_ff);
   assign luma = s0_phase_ff ? s0_c_ff : s0_a_ff;

   always_comb begin
      s1_v_in      = s1_adv ? issue : s1_v_ff;
      s1_base_r_in = s1_base_r_ff;
      s1_base_g_in = s1_base_g_ff;
      s1_base_b_in = s1_base_b_ff;
      s1_rv_in     = s1_rv_ff;
      s1_gu_in     = s1_gu_ff;
      s1_gv_in     = s1_gv_ff;
      s1_bu_in     = s1_bu_ff;
      s1_last_in   = s1_last_ff;
      if (issue) begin
         s1_last_in = done;
         if (s0_mode_ff == pfx_pkg::MODE_RGB24) begin
            s1_base_r_in = {s0_c_ff, 8'd0};
            s1_base_g_in = {s0_b_ff, 8'd0};
            s1_base_b_in = {s0_a_ff, 8'd0};
            s1_rv_in     = '0;
            s1_gu_in     = '0;
            s1_gv_in     = '0;
            s1_bu_in     = '0;
         end else begin
            s1_base_r_in = {luma, 8'd0};
            s1_base_g_in = {luma, 8'd0};
            s1_base_b_in = {luma, 8'd0};
            s1_rv_in     = v_c * pfx_pkg::COEF_RV;
            s1_gu_in     = u_c * pfx_pkg::COEF_GU;
            s1_gv_in     = v_c * pfx_pkg::COEF_GV;
            s1_bu_in     = u_c * pfx_pkg::COEF_BU;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_v_ff <= 1'b0;
      end else begin
         s1_v_ff <= s1_v_in;
      end
      s1_base_r_ff <= s1_base_r_in;
      s1_base_g_ff <= s1_base_g_in;
      s1_base_b_ff <= s1_base_b_in;
      s1_rv_ff     <= s1_rv_in;
      s1_gu_ff     <= s1_gu_in;
      s1_gv_ff     <= s1_gv_in;
      s1_bu_ff     <= s1_bu_in;
      s1_last_ff   <= s1_last_in;
   end

   // ------------------------------------------------------------------
   // Stage 2: accumulate. The sums need 19 signed bits; blue reaches the
   // widest range.
   // ------------------------------------------------------------------
   pfx_pkg::acc_type s2_r_ff, s2_r_in;
   pfx_pkg::acc_type s2_g_ff, s2_g_in;
   pfx_pkg::acc_type s2_b_ff, s2_b_in;
   logic             s2_last_ff, s2_last_in;
   logic             s1_move;

   assign s1_move = s1_v_ff && s2_adv;

   always_comb begin
      s2_v_in    = s2_adv ? s1_v_ff : s2_v_ff;
      s2_r_in    = s2_r_ff;
      s2_g_in    = s2_g_ff;
      s2_b_in    = s2_b_ff;
      s2_last_in = s2_last_ff;
      if (s1_move) begin
         s2_r_in    = pfx_pkg::acc_type'({3'd0, s1_base_r_ff}) + s1_rv_ff;
         s2_g_in    = pfx_pkg::acc_type'({3'd0, s1_base_g_ff}) - s1_gu_ff - s1_gv_ff;
         s2_b_in    = pfx_pkg::acc_type'({3'd0, s1_base_b_ff}) + s1_bu_ff;
         s2_last_in = s1_last_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_v_ff <= 1'b0;
      end else begin
         s2_v_ff <= s2_v_in;
      end
      s2_r_ff    <= s2_r_in;
      s2_g_ff    <= s2_g_in;
      s2_b_ff    <= s2_b_in;
      s2_last_ff <= s2_last_in;
   end

   // ------------------------------------------------------------------
   // Stage 3: floor shift and clamp into the output register. A pixel
   // waits here while rsp_ready is low, and the stages behind it keep
   // filling until they too are full.
   // ------------------------------------------------------------------
   logic [7:0] s3_r_ff, s3_r_in;
   logic [7:0] s3_g_ff, s3_g_in;
   logic [7:0] s3_b_ff, s3_b_in;
   logic       s3_last_ff, s3_last_in;
   logic       s2_move;

   assign s2_move = s2_v_ff && s3_adv;

   always_comb begin
      s3_v_in    = s3_adv ? s2_v_ff : s3_v_ff;
      s3_r_in    = s3_r_ff;
      s3_g_in    = s3_g_ff;
      s3_b_in    = s3_b_ff;
      s3_last_in = s3_last_ff;
      if (s2_move) begin
         s3_r_in    = pfx_pkg::clamp_q8(s2_r_ff);
         s3_g_in    = pfx_pkg::clamp_q8(s2_g_ff);
         s3_b_in    = pfx_pkg::clamp_q8(s2_b_ff);
         s3_last_in = s2_last_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_v_ff <= 1'b0;
      end else begin
         s3_v_ff <= s3_v_in;
      end
      s3_r_ff    <= s3_r_in;
      s3_g_ff    <= s3_g_in;
      s3_b_ff    <= s3_b_in;
      s3_last_ff <= s3_last_in;
   end

   assign rsp_valid = s3_v_ff;
   assign rsp_red   = s3_r_ff;
   assign rsp_green = s3_g_ff;
   assign rsp_blue  = s3_b_ff;
   assign rsp_alpha = pfx_pkg::ALPHA_OPAQUE;
   assign rsp_last  = s3_last_ff;

`ifndef SYNTHESIS
   // The second pixel of a macropixel is only ever pending for a full YUY2 item.
   a_phase_only_full_yuy2: assert property (@(posedge clock) disable iff (reset)
      s0_phase_ff |-> (s0_v_ff && !s0_tail_ff && (s0_mode_ff == pfx_pkg::MODE_YUY2)))
      else $error("second pixel pending for an item that has only one");

   // A full YUY2 transfer blocks the input for the cycle its first pixel issues.
   a_full_item_blocks: assert property (@(posedge clock) disable iff (reset)
      (accept && !req_one_pixel_only && (mode_ff == pfx_pkg::MODE_YUY2)) |=> !req_ready)
      else $error("input accepted again before both pixels were issued");

   // Leaving reset, the pipeline is empty and the input side is open.
   a_reset_empty: assert property (@(posedge clock)
      $past(reset) |-> (!rsp_valid && req_ready && !s1_v_ff && !s2_v_ff))
      else $error("pipeline not empty after reset");
`endif

endmodule

// ===== bench/tb.sv =====
// Self-checking bench for pixel_format_to_xrgb_core: YUY2 and RGB24 pixels in, XRGB pixels out.
// Depends on pfx_pkg for the mode enum and the register index; prediction is computed locally.
module tb;

   // Byte address of the mode register, and the next word, where no register lives.
   localparam logic [2:0] MODE_ADDR   = 3'(4 * int'(pfx_pkg::REG_CONVERSION_MODE));
   localparam logic [2:0] UNUSED_ADDR = MODE_ADDR + 3'd4;

   // Q8 conversion coefficients, each the float factor times 256 rounded to nearest.
   localparam int Q8_RED_V   = 292;
   localparam int Q8_GREEN_U = 101;
   localparam int Q8_GREEN_V = 149;
   localparam int Q8_BLUE_U  = 520;
   localparam int CHROMA_ZERO = 128;
   localparam logic [7:0] OPAQUE = 8'hFF;

   typedef struct {
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
      logic [7:0] alpha;
      logic       last;
   } pixel_type;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_ready;
   logic [7:0]  req_byte_a;
   logic [7:0]  req_byte_b;
   logic [7:0]  req_byte_c;
   logic [7:0]  req_byte_d;
   logic        req_one_pixel_only;
   logic        rsp_valid;
   logic        rsp_ready;
   logic [7:0]  rsp_red;
   logic [7:0]  rsp_green;
   logic [7:0]  rsp_blue;
   logic [7:0]  rsp_alpha;
   logic        rsp_last;
   logic        psel;
   logic        penable;
   logic        pwrite;
   logic [2:0]  paddr;
   logic [31:0] pwdata;
   logic [31:0] prdata;
   logic        pready;

   // Pixels the block still owes us, oldest first.
   pixel_type pixels_expected[$];

   // Our own copy of the mode register, updated when a write lands.
   pfx_pkg::mode_type mode_shadow = pfx_pkg::MODE_YUY2;

   // When set, both sides insert random idle bursts.
   bit idle_enabled = 1'b0;

   // The receiver picks this up and holds rsp_ready low for that many cycles.
   int hold_off_cycles = 0;

   int fail_count = 0;
   int mismatch_count = 0;
   int yuy2_items = 0;
   int rgb24_items = 0;
   int pixels_checked = 0;
   int register_writes = 0;

   pixel_format_to_xrgb_core i_dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_byte_a         (req_byte_a),
      .req_byte_b         (req_byte_b),
      .req_byte_c         (req_byte_c),
      .req_byte_d         (req_byte_d),
      .req_one_pixel_only (req_one_pixel_only),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_red            (rsp_red),
      .rsp_green          (rsp_green),
      .rsp_blue           (rsp_blue),
      .rsp_alpha          (rsp_alpha),
      .rsp_last           (rsp_last),
      .psel               (psel),
      .penable            (penable),
      .pwrite             (pwrite),
      .paddr              (paddr),
      .pwdata             (pwdata),
      .prdata             (prdata),
      .pready             (pready)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // Hard stop in case a handshake never completes. This is many times the slowest
   // legal run: every item with two pixels, maximal stalls on both sides, the long hold-off.
   initial begin
      #4000000;
      $display("status: fail");
      $finish;
   end

   // ---------------------------------------------------------------------------------------
   // Prediction
   // ---------------------------------------------------------------------------------------

   // Divide a Q8 accumulator by 256 rounding toward minus infinity, then saturate to a byte.
   // The arithmetic shift of a signed int gives the floor directly.
   function automatic logic [7:0] saturate_q8(input int acc);
      int whole;
      whole = acc >>> 8;
      if (whole < 0) begin
         return 8'd0;
      end else if (whole > 255) begin
         return 8'd255;
      end
      return whole[7:0];
   endfunction

   // One YUV sample to XRGB; cb and cr are already centered on zero.
   function automatic pixel_type yuv_to_xrgb(input int luma, input int cb, input int cr,
                                             input logic last);
      pixel_type px;
      px.red   = saturate_q8(luma * 256 + Q8_RED_V * cr);
      px.green = saturate_q8(luma * 256 - Q8_GREEN_U * cb - Q8_GREEN_V * cr);
      px.blue  = saturate_q8(luma * 256 + Q8_BLUE_U * cb);
      px.alpha = OPAQUE;
      px.last  = last;
      return px;
   endfunction

   // ---------------------------------------------------------------------------------------
   // Monitor: predicts on every input transfer and checks every output transfer. Both are
   // sampled right after the rising edge, where the values are the ones the edge saw.
   // ---------------------------------------------------------------------------------------
   always @(posedge clock) begin
      pixel_type got;
      pixel_type want;
      int cb;
      int cr;
      if (!reset) begin
         if (req_valid && req_ready) begin
            if (mode_shadow == pfx_pkg::MODE_RGB24) begin
               // Straight repack of B,G,R; the fourth byte and the tail flag do not matter.
               want.red   = req_byte_c;
               want.green = req_byte_b;
               want.blue  = req_byte_a;
               want.alpha = OPAQUE;
               want.last  = 1'b1;
               pixels_expected.push_back(want);
               rgb24_items++;
            end else begin
               cb = int'(req_byte_b) - CHROMA_ZERO;
               cr = int'(req_byte_d) - CHROMA_ZERO;
               if (req_one_pixel_only) begin
                  // Odd row tail: only the Y0 pixel, which closes the item.
                  pixels_expected.push_back(yuv_to_xrgb(int'(req_byte_a), cb, cr, 1'b1));
               end else begin
                  pixels_expected.push_back(yuv_to_xrgb(int'(req_byte_a), cb, cr, 1'b0));
                  pixels_expected.push_back(yuv_to_xrgb(int'(req_byte_c), cb, cr, 1'b1));
               end
               yuy2_items++;
            end
         end

         if (rsp_valid && rsp_ready) begin
            got.red   = rsp_red;
            got.green = rsp_green;
            got.blue  = rsp_blue;
            got.alpha = rsp_alpha;
            got.last  = rsp_last;
            if (pixels_expected.size() == 0) begin
               fail_count++;
               mismatch_count++;
               if (mismatch_count <= 10) begin
                  $display("unexpected pixel r=%0d g=%0d b=%0d a=%0d last=%0b",
                           got.red, got.green, got.blue, got.alpha, got.last);
               end
            end else begin
               want = pixels_expected.pop_front();
               pixels_checked++;
               if (got.red !== want.red || got.green !== want.green ||
                   got.blue !== want.blue || got.alpha !== want.alpha ||
                   got.last !== want.last) begin
                  fail_count++;
                  mismatch_count++;
                  if (mismatch_count <= 10) begin
                     $display("pixel mismatch: expected r=%0d g=%0d b=%0d a=%0d last=%0b",
                              want.red, want.green, want.blue, want.alpha, want.last);
                     $display("                actual   r=%0d g=%0d b=%0d a=%0d last=%0b",
                              got.red, got.green, got.blue, got.alpha, got.last);
                  end
               end
            end
         end
      end
   end

   // ---------------------------------------------------------------------------------------
   // Receiver: toggles rsp_ready in random stretches while idling is enabled, else keeps it
   // high. A hold-off request from a test takes priority and keeps ready low for a counted
   // number of cycles. Each pass of the loop makes one assignment and then waits on the clock.
   // ---------------------------------------------------------------------------------------
   initial begin
      rsp_ready <= 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (hold_off_cycles > 0) begin
            rsp_ready <= 1'b0;
            repeat (hold_off_cycles) @(posedge clock);
            hold_off_cycles = 0;
         end else if (idle_enabled && $urandom_range(0, 3) == 0) begin
            rsp_ready <= 1'b0;
            repeat ($urandom_range(1, 14)) @(posedge clock);
         end else begin
            rsp_ready <= 1'b1;
            repeat ($urandom_range(1, 20)) @(posedge clock);
         end
      end
   end

   // ---------------------------------------------------------------------------------------
   // Sender and register access
   // ---------------------------------------------------------------------------------------

   // Offer one item and return at the edge where it transfers. Valid stays high into the
   // next call unless that call opens an idle gap first.
   task automatic send_pixel_item(input logic [7:0] a, input logic [7:0] b,
                                  input logic [7:0] c, input logic [7:0] d,
                                  input logic tail);
      if (idle_enabled && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 14)) @(posedge clock);
      end
      req_valid          <= 1'b1;
      req_byte_a         <= a;
      req_byte_b         <= b;
      req_byte_c         <= c;
      req_byte_d         <= d;
      req_one_pixel_only <= tail;
      do @(posedge clock); while (!req_ready);
   endtask

   // Stop offering and wait until every predicted pixel has come out, plus a few cycles
   // so the block is fully idle before a register changes. The first edge lets the monitor
   // record a transfer that landed at the edge the caller returned on.
   task automatic drain_pipeline();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pixels_expected.size() != 0) @(posedge clock);
      repeat (6) @(posedge clock);
   endtask

   // APB write: setup cycle, then access cycle until pready.
   task automatic csr_write(input logic [2:0] addr, input logic [31:0] data);
      drain_pipeline();
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= addr;
      pwdata  <= data;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      // Only the mode register exists, and only its lowest bit is stored.
      if (addr == MODE_ADDR) begin
         mode_shadow = pfx_pkg::mode_type'(data[0]);
      end
      register_writes++;
   endtask

   // APB read of the mode register, compared with our shadow copy.
   task automatic csr_read_check();
      logic [31:0] want;
      drain_pipeline();
      want    = {31'd0, mode_shadow};
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      paddr   <= MODE_ADDR;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      if (prdata !== want) begin
         fail_count++;
         mismatch_count++;
         if (mismatch_count <= 10) begin
            $display("mode register read: expected %08h actual %08h", want, prdata);
         end
      end
      psel    <= 1'b0;
      penable <= 1'b0;
   endtask

   // Random byte, leaning toward the values that drive the clamps and the chroma center.
   function automatic logic [7:0] pick_byte();
      case ($urandom_range(0, 7))
         0: return 8'd0;
         1: return 8'd255;
         2: return 8'd128;
         default: return 8'($urandom_range(0, 255));
      endcase
   endfunction

   // ---------------------------------------------------------------------------------------
   // Tests
   // ---------------------------------------------------------------------------------------

   // Reset value, a write to an address with no register behind it, and masking of the
   // upper data bits on a real write.
   task automatic check_register_access();
      csr_read_check();
      csr_write(UNUSED_ADDR, 32'hFFFF_FFFF);
      csr_read_check();
      csr_write(MODE_ADDR, 32'h0000_0001);
      csr_read_check();
      csr_write(MODE_ADDR, 32'hFFFF_FFFE);
      csr_read_check();
   endtask

   // YUY2 corners: saturation in both directions on every channel, neutral chroma,
   // full macropixels and odd row tails.
   task automatic run_yuy2_corners();
      csr_write(MODE_ADDR, 32'(pfx_pkg::MODE_YUY2));
      send_pixel_item(8'd0,   8'd0,   8'd255, 8'd0,   1'b0);
      send_pixel_item(8'd255, 8'd255, 8'd0,   8'd255, 1'b0);
      send_pixel_item(8'd0,   8'd128, 8'd255, 8'd128, 1'b0);
      send_pixel_item(8'd255, 8'd0,   8'd0,   8'd255, 1'b0);
      send_pixel_item(8'd0,   8'd255, 8'd255, 8'd0,   1'b0);
      send_pixel_item(8'd16,  8'd128, 8'd235, 8'd128, 1'b0);
      send_pixel_item(8'd76,  8'd85,  8'd150, 8'd255, 1'b0);
      send_pixel_item(8'd128, 8'd0,   8'd128, 8'd0,   1'b1);
      send_pixel_item(8'd255, 8'd255, 8'd255, 8'd255, 1'b1);
      send_pixel_item(8'd0,   8'd0,   8'd0,   8'd0,   1'b1);
      send_pixel_item(8'd170, 8'd127, 8'd85,  8'd129, 1'b0);
   endtask

   // RGB24 repack; the tail flag and the fourth byte must have no effect.
   task automatic run_rgb24_corners();
      csr_write(MODE_ADDR, 32'(pfx_pkg::MODE_RGB24));
      send_pixel_item(8'd0,   8'd0,   8'd0,   8'd0,   1'b0);
      send_pixel_item(8'd255, 8'd255, 8'd255, 8'd255, 1'b1);
      send_pixel_item(8'd1,   8'd2,   8'd3,   8'd4,   1'b0);
      send_pixel_item(8'd170, 8'd85,  8'd170, 8'd85,  1'b1);
      send_pixel_item(8'd255, 8'd0,   8'd128, 8'd77,  1'b0);
   endtask

   // Random content in one mode. Upper register bits are random to exercise masking, and
   // idling is switched on or off every so often to get both throttled and full-rate runs.
   task automatic run_random_conversion(input pfx_pkg::mode_type mode, input int count);
      csr_write(MODE_ADDR, {31'($urandom()), mode});
      for (int n = 0; n < count; n++) begin
         if (n % 64 == 0) begin
            idle_enabled = ($urandom_range(0, 3) != 0);
         end
         send_pixel_item(pick_byte(), pick_byte(), pick_byte(), pick_byte(),
                         $urandom_range(0, 4) == 0);
      end
      idle_enabled = 1'b1;
   endtask

   // The receiver stops for a long stretch while the sender keeps offering full
   // macropixels, so the pipeline fills and req_ready must drop.
   task automatic run_output_backpressure();
      csr_write(MODE_ADDR, 32'(pfx_pkg::MODE_YUY2));
      idle_enabled = 1'b0;
      hold_off_cycles = 300;
      for (int n = 0; n < 40; n++) begin
         send_pixel_item(8'($urandom()), 8'($urandom()), 8'($urandom()), 8'($urandom()),
                         1'b0);
      end
      drain_pipeline();
      idle_enabled = 1'b1;
   endtask

   // Final stretch with no idling on either side, YUY2 then RGB24.
   task automatic run_unthrottled_tail();
      idle_enabled = 1'b0;
      csr_write(MODE_ADDR, 32'(pfx_pkg::MODE_YUY2));
      for (int n = 0; n < 60; n++) begin
         send_pixel_item(8'($urandom()), 8'($urandom()), 8'($urandom()), 8'($urandom()),
                         $urandom_range(0, 3) == 0);
      end
      csr_write(MODE_ADDR, 32'(pfx_pkg::MODE_RGB24));
      for (int n = 0; n < 20; n++) begin
         send_pixel_item(8'($urandom()), 8'($urandom()), 8'($urandom()), 8'($urandom()),
                         1'($urandom()));
      end
   endtask

   // ---------------------------------------------------------------------------------------
   // Sequence
   // ---------------------------------------------------------------------------------------
   initial begin
      reset              <= 1'b1;
      req_valid          <= 1'b0;
      req_byte_a         <= 8'd0;
      req_byte_b         <= 8'd0;
      req_byte_c         <= 8'd0;
      req_byte_d         <= 8'd0;
      req_one_pixel_only <= 1'b0;
      psel               <= 1'b0;
      penable            <= 1'b0;
      pwrite             <= 1'b0;
      paddr              <= 3'd0;
      pwdata             <= 32'd0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      idle_enabled = 1'b1;
      check_register_access();
      run_yuy2_corners();
      run_rgb24_corners();
      run_random_conversion(pfx_pkg::MODE_YUY2, 280);
      run_random_conversion(pfx_pkg::MODE_RGB24, 160);
      run_random_conversion(pfx_pkg::MODE_YUY2, 200);
      run_random_conversion(pfx_pkg::MODE_RGB24, 60);
      run_output_backpressure();
      run_unthrottled_tail();

      // Everything has been offered; wait for the last pixels and then longer than the
      // pipeline takes to empty, to catch any stray output.
      drain_pipeline();
      repeat (20) @(posedge clock);
      if (pixels_expected.size() != 0) begin
         fail_count++;
      end

      $display("Covered %0d YUY2 and %0d RGB24 input transfers, %0d pixels checked,",
               yuy2_items, rgb24_items, pixels_checked);
      $display("%0d register writes, clamp corners, row tails and a long output stall.",
               register_writes);
      if (fail_count == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule
